[design/pid_with_crossing_integral_reset_unit_macros.svh]
// Assertion macros shared by the PID controller checker.
`ifndef PID_WITH_CROSSING_INTEGRAL_RESET_UNIT_MACROS_SVH
`define PID_WITH_CROSSING_INTEGRAL_RESET_UNIT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define PIDCIR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PIDCIR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/pidcir_pkg.sv]
// Constants, types and saturation helpers for the PID controller.
`default_nettype none

package pidcir_pkg;

   localparam int DATA_WIDTH      = 16;
   localparam int GAIN_WIDTH      = 16;
   localparam int GAIN_FRAC_BITS  = 8;
   localparam int ACC_WIDTH       = 32;
   localparam int ERR_WIDTH       = DATA_WIDTH + 1;
   localparam int DIFF_WIDTH      = ERR_WIDTH + 1;
   localparam int DRIVE_WIDTH     = ACC_WIDTH;
   localparam int CSR_DATA_WIDTH  = (DATA_WIDTH > GAIN_WIDTH) ? DATA_WIDTH : GAIN_WIDTH;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam int PROD_P_WIDTH = GAIN_WIDTH + ERR_WIDTH;
   localparam int PROD_I_WIDTH = GAIN_WIDTH + ACC_WIDTH;
   localparam int PROD_D_WIDTH = GAIN_WIDTH + DIFF_WIDTH;
   localparam int SUM_WIDTH    = PROD_I_WIDTH + 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SETPOINT,
      CSR_GAIN_P,
      CSR_GAIN_I,
      CSR_GAIN_D
   } csr_index_type;

   typedef enum logic {
      OP_SAMPLE,
      OP_CLEAR
   } op_type;

   // Clamp a one-bit-wider sum into the accumulator range.
   function automatic logic signed [ACC_WIDTH-1:0] sat_integral(
      input logic signed [ACC_WIDTH:0] x
   );
      logic signed [ACC_WIDTH-1:0] result;
      if (x[ACC_WIDTH] != x[ACC_WIDTH-1]) begin
         result = x[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                               : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end else begin
         result = x[ACC_WIDTH-1:0];
      end
      return result;
   endfunction

   // Floor-shift out the gain fraction, then clamp into the drive range.
   function automatic logic signed [DRIVE_WIDTH-1:0] sat_drive(
      input logic signed [SUM_WIDTH-1:0] x
   );
      logic signed [SUM_WIDTH-1:0]          shifted;
      logic [SUM_WIDTH-DRIVE_WIDTH:0]       upper;
      logic signed [DRIVE_WIDTH-1:0]        result;
      shifted = x >>> GAIN_FRAC_BITS;
      upper   = shifted[SUM_WIDTH-1:DRIVE_WIDTH-1];
      if ((&upper) || !(|upper)) begin
         result = shifted[DRIVE_WIDTH-1:0];
      end else begin
         result = upper[SUM_WIDTH-DRIVE_WIDTH] ? {1'b1, {(DRIVE_WIDTH-1){1'b0}}}
                                               : {1'b0, {(DRIVE_WIDTH-1){1'b1}}};
      end
      return result;
   endfunction

endpackage

`default_nettype wire

[design/pid_with_crossing_integral_reset_unit.sv]
// PID controller top level: input register, error/integral stage, multiply stage, sum and saturate stage.
// An accepted beat moves through the input, stage 2, stage 3 and output registers to rsp_valid.
// Throughput: one beat per cycle while the output is not stalled; the integral and prior
// error update in the first stage, so back-to-back samples see each other's state.
// Stalls: each stage holds only while full and blocked downstream.
// Reset (synchronous): clears gains, setpoint, controller state and all valid bits.
`default_nettype none

module pid_with_crossing_integral_reset_unit (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_ready,
   input  logic                                          req_op,
   input  logic signed [pidcir_pkg::DATA_WIDTH-1:0]      req_measurement,
   output logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   output logic signed [pidcir_pkg::DRIVE_WIDTH-1:0]     rsp_drive,
   output logic signed [pidcir_pkg::ERR_WIDTH-1:0]       rsp_error_now,
   input  logic                                          csr_wr_en,
   input  logic [pidcir_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [pidcir_pkg::CSR_DATA_WIDTH-1:0]         csr_wdata
);

   // Configuration registers
   logic signed [pidcir_pkg::DATA_WIDTH-1:0] setpoint_ff;
   logic signed [pidcir_pkg::GAIN_WIDTH-1:0] gain_p_ff;
   logic signed [pidcir_pkg::GAIN_WIDTH-1:0] gain_i_ff;
   logic signed [pidcir_pkg::GAIN_WIDTH-1:0] gain_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= '0;
         gain_p_ff   <= '0;
         gain_i_ff   <= '0;
         gain_d_ff   <= '0;
      end else if (csr_wr_en) begin
         case (pidcir_pkg::csr_index_type'(csr_index))
            pidcir_pkg::CSR_SETPOINT: setpoint_ff <= csr_wdata[pidcir_pkg::DATA_WIDTH-1:0];
            pidcir_pkg::CSR_GAIN_P:   gain_p_ff   <= csr_wdata[pidcir_pkg::GAIN_WIDTH-1:0];
            pidcir_pkg::CSR_GAIN_I:   gain_i_ff   <= csr_wdata[pidcir_pkg::GAIN_WIDTH-1:0];
            pidcir_pkg::CSR_GAIN_D:   gain_d_ff   <= csr_wdata[pidcir_pkg::GAIN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline valid bits and per-stage ready
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_ready, s2_ready, s3_ready, out_ready;

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign s3_ready  = !s3_valid_ff || out_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready)  s1_valid_ff  <= req_valid;
         if (s2_ready)  s2_valid_ff  <= s1_valid_ff;
         if (s3_ready)  s3_valid_ff  <= s2_valid_ff;
         if (out_ready) rsp_valid_ff <= s3_valid_ff;
      end
   end

   // Stage 1: input register
   logic                                     s1_op_ff;
   logic signed [pidcir_pkg::DATA_WIDTH-1:0] s1_meas_ff;

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_op_ff   <= req_op;
         s1_meas_ff <= req_measurement;
      end
   end

   // Controller state
   logic signed [pidcir_pkg::ACC_WIDTH-1:0] integral_ff, integral_in;
   logic signed [pidcir_pkg::ERR_WIDTH-1:0] prior_err_ff, prior_err_in;
   logic                                    first_ff, first_in;

   logic signed [pidcir_pkg::ERR_WIDTH-1:0]  err;
   logic signed [pidcir_pkg::ERR_WIDTH-1:0]  prior_eff;
   logic signed [pidcir_pkg::ACC_WIDTH:0]    acc_sum;
   logic signed [pidcir_pkg::ACC_WIDTH-1:0]  integral_new;
   logic signed [pidcir_pkg::DIFF_WIDTH-1:0] diff;
   logic                                     err_pos, err_neg, prior_pos, prior_neg;
   logic                                     crossing, is_clear, fire1;

   always_comb begin
      is_clear  = (s1_op_ff == pidcir_pkg::OP_CLEAR);
      fire1     = s1_valid_ff && s2_ready;
      err       = pidcir_pkg::ERR_WIDTH'(setpoint_ff) - pidcir_pkg::ERR_WIDTH'(s1_meas_ff);
      // first sample after reset or clear: no derivative, no crossing
      prior_eff = first_ff ? err : prior_err_ff;
      acc_sum   = (pidcir_pkg::ACC_WIDTH + 1)'(integral_ff)
                + (pidcir_pkg::ACC_WIDTH + 1)'(err);
      err_neg   = err[pidcir_pkg::ERR_WIDTH-1];
      err_pos   = !err[pidcir_pkg::ERR_WIDTH-1] && (|err);
      prior_neg = prior_eff[pidcir_pkg::ERR_WIDTH-1];
      prior_pos = !prior_eff[pidcir_pkg::ERR_WIDTH-1] && (|prior_eff);
      crossing  = (err_neg && prior_pos) || (err_pos && prior_neg);
      integral_new = crossing ? '0 : pidcir_pkg::sat_integral(acc_sum);
      diff      = pidcir_pkg::DIFF_WIDTH'(prior_eff) - pidcir_pkg::DIFF_WIDTH'(err);

      integral_in  = integral_ff;
      prior_err_in = prior_err_ff;
      first_in     = first_ff;
      if (fire1) begin
         if (is_clear) begin
            integral_in  = '0;
            prior_err_in = '0;
            first_in     = 1'b1;
         end else begin
            integral_in  = integral_new;
            prior_err_in = err;
            first_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff  <= '0;
         prior_err_ff <= '0;
         first_ff     <= 1'b1;
      end else begin
         integral_ff  <= integral_in;
         prior_err_ff <= prior_err_in;
         first_ff     <= first_in;
      end
   end

   // Stage 2: terms; a clear beat carries zeros so its drive comes out zero
   logic signed [pidcir_pkg::ERR_WIDTH-1:0]  s2_err_ff;
   logic signed [pidcir_pkg::ACC_WIDTH-1:0]  s2_integral_ff;
   logic signed [pidcir_pkg::DIFF_WIDTH-1:0] s2_diff_ff;

   always_ff @(posedge clock) begin
      if (fire1) begin
         s2_err_ff      <= is_clear ? '0 : err;
         s2_integral_ff <= is_clear ? '0 : integral_new;
         s2_diff_ff     <= is_clear ? '0 : diff;
      end
   end

   // Stage 3: products
   logic signed [pidcir_pkg::PROD_P_WIDTH-1:0] s3_prod_p_ff;
   logic signed [pidcir_pkg::PROD_I_WIDTH-1:0] s3_prod_i_ff;
   logic signed [pidcir_pkg::PROD_D_WIDTH-1:0] s3_prod_d_ff;
   logic signed [pidcir_pkg::ERR_WIDTH-1:0]    s3_err_ff;

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_prod_p_ff <= gain_p_ff * s2_err_ff;
         s3_prod_i_ff <= gain_i_ff * s2_integral_ff;
         s3_prod_d_ff <= gain_d_ff * s2_diff_ff;
         s3_err_ff    <= s2_err_ff;
      end
   end

   // Output stage: sum, floor shift, saturate
   logic signed [pidcir_pkg::SUM_WIDTH-1:0]   pid_sum;
   logic signed [pidcir_pkg::DRIVE_WIDTH-1:0] rsp_drive_ff;
   logic signed [pidcir_pkg::ERR_WIDTH-1:0]   rsp_error_ff;

   assign pid_sum = pidcir_pkg::SUM_WIDTH'(s3_prod_p_ff)
                  + pidcir_pkg::SUM_WIDTH'(s3_prod_i_ff)
                  + pidcir_pkg::SUM_WIDTH'(s3_prod_d_ff);

   always_ff @(posedge clock) begin
      if (out_ready && s3_valid_ff) begin
         rsp_drive_ff <= pidcir_pkg::sat_drive(pid_sum);
         rsp_error_ff <= s3_err_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = rsp_drive_ff;
   assign rsp_error_now = rsp_error_ff;

endmodule

`default_nettype wire

[design/pidcir_checker.sv]
// Port-level checker for the PID controller, bound to the top level.
`default_nettype none

`include "pid_with_crossing_integral_reset_unit_macros.svh"

module pidcir_checker (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   input  logic signed [pidcir_pkg::DRIVE_WIDTH-1:0]     rsp_drive,
   input  logic signed [pidcir_pkg::ERR_WIDTH-1:0]       rsp_error_now
);

   logic signed [pidcir_pkg::ERR_WIDTH-1:0] err_most_negative;
   assign err_most_negative = {1'b1, {(pidcir_pkg::ERR_WIDTH-1){1'b0}}};

   // a difference of two data words never reaches the most negative error code
   property p_err_range;
      rsp_valid |-> rsp_error_now != err_most_negative;
   endproperty

   // a stalled result beat holds
   property p_rsp_hold;
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive) && $stable(rsp_error_now);
   endproperty

   // reset empties the pipeline
   `PIDCIR_ASSERT_ALWAYS(a_reset_flush, clock, reset |=> !rsp_valid, "rsp_valid after reset")

   `PIDCIR_ASSERT(a_err_range, clock, reset, p_err_range, "error_now out of range")

   `PIDCIR_ASSERT(a_rsp_hold, clock, reset, p_rsp_hold, "stalled result changed")

endmodule

bind pid_with_crossing_integral_reset_unit pidcir_checker u_pidcir_checker (.*);

`default_nettype wire
